// ===== sv/dscf_pkg.sv =====
// Shared types, constants and the microcode table of the daisy chain command framer.
`default_nettype none

package dscf_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned MODE_W = 2;
  localparam int unsigned DEV_W  = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BC_W   = 2;
  localparam int unsigned VAL_W  = 24;
  localparam int unsigned CFG_W  = 4;

  // Value bytes are picked out of a zero-extended word of up to four bytes.
  localparam int unsigned VAL_EXT_W = 32;

  // Default sizes of the block.
  localparam int unsigned MAX_CHAIN       = 8;
  localparam int unsigned MAX_VALUE_BYTES = 3;

  // Chain length after reset and the read flag that is or-ed into a read command.
  localparam logic [CFG_W-1:0]  CHAIN_RESET = 4'd4;
  localparam logic [BYTE_W-1:0] READ_FLAG   = 8'h20;

  // Request kinds.
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_RAW   = 2'd2,
    MODE_RX    = 2'd3
  } mode_e;

  // Microcode addresses.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_CMD,
    ST_WR_VAL,
    ST_RD_CMD,
    ST_RD_ZERO,
    ST_RAW,
    ST_RX
  } step_e;

  // Sequencing kind of a control word.
  typedef enum logic [1:0] {
    SEQ_DISPATCH,
    SEQ_FRAME,
    SEQ_RX
  } seq_e;

  // Source of the payload byte of a frame.
  typedef enum logic [1:0] {
    SRC_CMD,
    SRC_CMD_RD,
    SRC_VALUE,
    SRC_ZERO
  } src_e;

  // One control word of the microcode table.
  typedef struct packed {
    seq_e  seq;      // how the step counter moves
    src_e  src;      // payload byte of the frame
    logic  cnt_chk;  // more frames may follow this one
    logic  dec;      // this frame uses up one value frame
    logic  rd_flag;  // a read command that ends here reports an empty result
    step_e next;     // jump target when more frames follow
  } ctrl_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    ctrl_t cw;
    logic  accept;
    logic  fire;
  } seq_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic frame_last;
    logic more;
    logic pending;
    logic slot_free;
  } stat_t;

  // Microcode table: one control word per step.
  function automatic ctrl_t ucode(input step_e s);
    ctrl_t cw;
    cw = '{seq: SEQ_DISPATCH, src: SRC_ZERO, cnt_chk: 1'b0, dec: 1'b0,
           rd_flag: 1'b0, next: ST_IDLE};
    case (s)
      ST_IDLE: begin
        cw = '{seq: SEQ_DISPATCH, src: SRC_ZERO, cnt_chk: 1'b0, dec: 1'b0,
               rd_flag: 1'b0, next: ST_IDLE};
      end
      ST_WR_CMD: begin
        cw = '{seq: SEQ_FRAME, src: SRC_CMD, cnt_chk: 1'b1, dec: 1'b0,
               rd_flag: 1'b0, next: ST_WR_VAL};
      end
      ST_WR_VAL: begin
        cw = '{seq: SEQ_FRAME, src: SRC_VALUE, cnt_chk: 1'b1, dec: 1'b1,
               rd_flag: 1'b0, next: ST_WR_VAL};
      end
      ST_RD_CMD: begin
        cw = '{seq: SEQ_FRAME, src: SRC_CMD_RD, cnt_chk: 1'b1, dec: 1'b0,
               rd_flag: 1'b1, next: ST_RD_ZERO};
      end
      ST_RD_ZERO: begin
        cw = '{seq: SEQ_FRAME, src: SRC_ZERO, cnt_chk: 1'b1, dec: 1'b1,
               rd_flag: 1'b0, next: ST_RD_ZERO};
      end
      ST_RAW: begin
        cw = '{seq: SEQ_FRAME, src: SRC_CMD, cnt_chk: 1'b0, dec: 1'b0,
               rd_flag: 1'b0, next: ST_IDLE};
      end
      ST_RX: begin
        cw = '{seq: SEQ_RX, src: SRC_ZERO, cnt_chk: 1'b0, dec: 1'b0,
               rd_flag: 1'b0, next: ST_IDLE};
      end
      default: begin
        cw = '{seq: SEQ_DISPATCH, src: SRC_ZERO, cnt_chk: 1'b0, dec: 1'b0,
               rd_flag: 1'b0, next: ST_IDLE};
      end
    endcase
    return cw;
  endfunction

  // Entry step of each request kind.
  function automatic step_e dispatch(input logic [MODE_W-1:0] mode);
    step_e s;
    case (mode_e'(mode))
      MODE_WRITE: s = ST_WR_CMD;
      MODE_READ:  s = ST_RD_CMD;
      MODE_RAW:   s = ST_RAW;
      MODE_RX:    s = ST_RX;
      default:    s = ST_IDLE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dscf_if.sv =====
// Request and result channel interfaces of the daisy chain command framer.
`default_nettype none

interface dscf_in_if;
  logic                         valid;
  logic                         ready;
  logic [dscf_pkg::MODE_W-1:0]  mode;
  logic [dscf_pkg::DEV_W-1:0]   device_index;
  logic [dscf_pkg::BYTE_W-1:0]  command_byte;
  logic [dscf_pkg::BC_W-1:0]    byte_count;
  logic [dscf_pkg::VAL_W-1:0]   value;
  logic [dscf_pkg::BYTE_W-1:0]  rx_byte;

  modport source (
    output valid, mode, device_index, command_byte, byte_count, value, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, device_index, command_byte, byte_count, value, rx_byte,
    output ready
  );
endinterface

interface dscf_out_if;
  logic                         valid;
  logic                         ready;
  logic [dscf_pkg::BYTE_W-1:0]  tx_byte;
  logic                         frame_end;
  logic                         target_slot;
  logic                         read_valid;
  logic [dscf_pkg::VAL_W-1:0]   read_value;
  logic                         last;

  modport source (
    output valid, tx_byte, frame_end, target_slot, read_valid, read_value, last,
    input  ready
  );
  modport sink (
    input  valid, tx_byte, frame_end, target_slot, read_valid, read_value, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/dscf_sequencer.sv =====
// Step counter, microcode lookup and dispatch of the daisy chain command framer.
`default_nettype none

module dscf_sequencer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [dscf_pkg::MODE_W-1:0] in_mode_i,
  output logic                             in_ready_o,
  input  wire dscf_pkg::stat_t             stat_i,
  output dscf_pkg::seq_ctrl_t              ctrl_o
);

  dscf_pkg::step_e step_q, step_d;
  dscf_pkg::ctrl_t cw;
  logic            accept;
  logic            fire;

  // Step register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= dscf_pkg::ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Control word lookup and next step.
  always_comb begin
    cw         = dscf_pkg::ucode(step_q);
    in_ready_o = (cw.seq == dscf_pkg::SEQ_DISPATCH);
    accept     = in_ready_o && in_valid_i;
    fire       = 1'b0;
    step_d     = step_q;
    case (cw.seq)
      dscf_pkg::SEQ_DISPATCH: begin
        if (accept) begin
          step_d = dscf_pkg::dispatch(in_mode_i);
        end
      end
      dscf_pkg::SEQ_FRAME: begin
        // One byte per cycle while the result register has room.
        if (stat_i.slot_free) begin
          fire = 1'b1;
          if (stat_i.frame_last) begin
            step_d = stat_i.more ? cw.next : dscf_pkg::ST_IDLE;
          end
        end
      end
      dscf_pkg::SEQ_RX: begin
        // A received byte with no read open finishes without a result.
        if (!stat_i.pending || stat_i.slot_free) begin
          fire   = 1'b1;
          step_d = dscf_pkg::ST_IDLE;
        end
      end
      default: begin
        step_d = dscf_pkg::ST_IDLE;
      end
    endcase
  end

  assign ctrl_o = '{cw: cw, accept: accept, fire: fire};

  // An accepted request always leaves the idle step.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> step_q != dscf_pkg::ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

endmodule

`default_nettype wire

// ===== sv/dscf_datapath.sv =====
// Frame byte generation, read collection and result register of the command framer.
`default_nettype none

module dscf_datapath #(
  parameter int unsigned MAX_CHAIN       = dscf_pkg::MAX_CHAIN,
  parameter int unsigned MAX_VALUE_BYTES = dscf_pkg::MAX_VALUE_BYTES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [dscf_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic [dscf_pkg::MODE_W-1:0] in_mode_i,
  input  wire logic [dscf_pkg::DEV_W-1:0]  in_device_index_i,
  input  wire logic [dscf_pkg::BYTE_W-1:0] in_command_byte_i,
  input  wire logic [dscf_pkg::BC_W-1:0]   in_byte_count_i,
  input  wire logic [dscf_pkg::VAL_W-1:0]  in_value_i,
  input  wire logic [dscf_pkg::BYTE_W-1:0] in_rx_byte_i,
  input  wire dscf_pkg::seq_ctrl_t         ctrl_i,
  output dscf_pkg::stat_t                  stat_o,
  dscf_out_if.source                       out_o
);

  localparam int unsigned LEN_W = $clog2(MAX_CHAIN + 1);
  localparam int unsigned CNT_W = $clog2(MAX_VALUE_BYTES + 1);
  localparam int unsigned CMP_W = (LEN_W > dscf_pkg::DEV_W) ? LEN_W : dscf_pkg::DEV_W;
  localparam int unsigned BW    = dscf_pkg::BYTE_W;
  localparam int unsigned VW    = dscf_pkg::VAL_W;

  // Configuration register.
  logic [dscf_pkg::CFG_W-1:0] chain_q, chain_d;

  // Request registers.
  logic [dscf_pkg::DEV_W-1:0] dev_q, dev_d;
  logic [BW-1:0]              cmd_q, cmd_d;
  logic [VW-1:0]              val_q, val_d;
  logic [BW-1:0]              rx_q, rx_d;

  // Frame counters.
  logic [LEN_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0] frames_left_q, frames_left_d;

  // Read state.
  logic                       pending_q, pending_d;
  logic [dscf_pkg::DEV_W-1:0] rd_dev_q, rd_dev_d;
  logic [CNT_W-1:0]           bytes_left_q, bytes_left_d;
  logic [LEN_W-1:0]           rx_slot_q, rx_slot_d;
  logic [VW-1:0]              acc_q, acc_d;

  // Result register.
  logic          out_valid_q, out_valid_d;
  logic [BW-1:0] tx_q, tx_d;
  logic          fend_q, fend_d;
  logic          tgt_q, tgt_d;
  logic          rv_q, rv_d;
  logic [VW-1:0] rval_q, rval_d;
  logic          last_q, last_d;

  // Combinational terms.
  logic [LEN_W-1:0]             len;
  logic [CNT_W-1:0]             bc_sat;
  logic                         frame_last;
  logic                         tx_hit;
  logic                         more;
  logic [CNT_W-1:0]             val_idx;
  logic [dscf_pkg::VAL_EXT_W-1:0] val_shifted;
  logic [BW-1:0]                src_byte;
  logic [LEN_W-1:0]             rx_slot_c;
  logic                         rx_hit;
  logic                         rx_wrap;
  logic                         rx_done;
  logic [VW-1:0]                acc_new;
  logic                         slot_free;
  logic                         frame_fire;
  logic                         rx_fire;

  function automatic logic mode_is_read(input logic [dscf_pkg::MODE_W-1:0] m);
    return dscf_pkg::mode_e'(m) == dscf_pkg::MODE_READ;
  endfunction

  // Effective chain length: zero acts as one, long chains are capped.
  always_comb begin
    if (chain_q == '0) begin
      len = LEN_W'(1);
    end else if (32'(chain_q) > MAX_CHAIN) begin
      len = LEN_W'(MAX_CHAIN);
    end else begin
      len = LEN_W'(chain_q);
    end
  end

  // Value byte count, capped at the largest supported count.
  assign bc_sat = (32'(in_byte_count_i) > MAX_VALUE_BYTES) ? CNT_W'(MAX_VALUE_BYTES)
                                                           : CNT_W'(in_byte_count_i);

  // Byte k of a frame belongs to device len - k.
  assign frame_last = (slot_q == len - LEN_W'(1));
  assign tx_hit     = (CMP_W'(dev_q) == CMP_W'(len - slot_q));
  assign more       = ctrl_i.cw.cnt_chk &&
                      (ctrl_i.cw.dec ? (frames_left_q != CNT_W'(1))
                                     : (frames_left_q != '0));

  // Value frames go out most significant byte first.
  assign val_idx     = frames_left_q - CNT_W'(1);
  assign val_shifted = dscf_pkg::VAL_EXT_W'(val_q) >> {val_idx, 3'b000};

  always_comb begin
    case (ctrl_i.cw.src)
      dscf_pkg::SRC_CMD:    src_byte = cmd_q;
      dscf_pkg::SRC_CMD_RD: src_byte = cmd_q | dscf_pkg::READ_FLAG;
      dscf_pkg::SRC_VALUE:  src_byte = val_shifted[BW-1:0];
      dscf_pkg::SRC_ZERO:   src_byte = '0;
      default:              src_byte = '0;
    endcase
  end

  // Received byte: slot position, target match and shift into the value.
  assign rx_slot_c = (rx_slot_q >= len) ? (len - LEN_W'(1)) : rx_slot_q;
  assign rx_hit    = (CMP_W'(rd_dev_q) == CMP_W'(len - rx_slot_c));
  assign acc_new   = rx_hit ? {acc_q[VW-BW-1:0], rx_q} : acc_q;
  assign rx_wrap   = (rx_slot_c == len - LEN_W'(1));
  assign rx_done   = rx_wrap && (bytes_left_q == CNT_W'(1));

  assign slot_free  = !out_valid_q || out_o.ready;
  assign frame_fire = ctrl_i.fire && (ctrl_i.cw.seq == dscf_pkg::SEQ_FRAME);
  assign rx_fire    = ctrl_i.fire && (ctrl_i.cw.seq == dscf_pkg::SEQ_RX) && pending_q;

  // Next state of all registers.
  always_comb begin
    chain_d       = chain_q;
    dev_d         = dev_q;
    cmd_d         = cmd_q;
    val_d         = val_q;
    rx_d          = rx_q;
    slot_d        = slot_q;
    frames_left_d = frames_left_q;
    pending_d     = pending_q;
    rd_dev_d      = rd_dev_q;
    bytes_left_d  = bytes_left_q;
    rx_slot_d     = rx_slot_q;
    acc_d         = acc_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    tx_d          = tx_q;
    fend_d        = fend_q;
    tgt_d         = tgt_q;
    rv_d          = rv_q;
    rval_d        = rval_q;
    last_d        = last_q;

    if (cfg_we_i) begin
      chain_d = cfg_wdata_i;
    end

    // Latch a new request; a read request opens a fresh read.
    if (ctrl_i.accept) begin
      dev_d         = in_device_index_i;
      cmd_d         = in_command_byte_i;
      val_d         = in_value_i;
      rx_d          = in_rx_byte_i;
      slot_d        = '0;
      frames_left_d = bc_sat;
      if (mode_is_read(in_mode_i)) begin
        rd_dev_d     = in_device_index_i;
        rx_slot_d    = '0;
        acc_d        = '0;
        pending_d    = (bc_sat != '0);
        bytes_left_d = bc_sat;
      end
    end

    // One frame byte.
    if (frame_fire) begin
      slot_d = frame_last ? '0 : slot_q + LEN_W'(1);
      if (frame_last && ctrl_i.cw.dec) begin
        frames_left_d = frames_left_q - CNT_W'(1);
      end
      out_valid_d = 1'b1;
      tx_d        = tx_hit ? src_byte : '0;
      fend_d      = frame_last;
      tgt_d       = tx_hit;
      rv_d        = ctrl_i.cw.rd_flag && frame_last && !more;
      rval_d      = '0;
      last_d      = frame_last && !more;
    end

    // One received byte of an open read.
    if (rx_fire) begin
      rx_slot_d   = rx_wrap ? '0 : rx_slot_c + LEN_W'(1);
      bytes_left_d = rx_wrap ? bytes_left_q - CNT_W'(1) : bytes_left_q;
      acc_d       = rx_done ? '0 : acc_new;
      pending_d   = !rx_done;
      out_valid_d = 1'b1;
      tx_d        = '0;
      fend_d      = 1'b0;
      tgt_d       = rx_hit;
      rv_d        = rx_done;
      rval_d      = rx_done ? acc_new : '0;
      last_d      = 1'b1;
    end
  end

  // Control and read state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q       <= dscf_pkg::CHAIN_RESET;
      slot_q        <= '0;
      frames_left_q <= '0;
      pending_q     <= 1'b0;
      rd_dev_q      <= '0;
      bytes_left_q  <= '0;
      rx_slot_q     <= '0;
      acc_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      chain_q       <= chain_d;
      slot_q        <= slot_d;
      frames_left_q <= frames_left_d;
      pending_q     <= pending_d;
      rd_dev_q      <= rd_dev_d;
      bytes_left_q  <= bytes_left_d;
      rx_slot_q     <= rx_slot_d;
      acc_q         <= acc_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    dev_q  <= dev_d;
    cmd_q  <= cmd_d;
    val_q  <= val_d;
    rx_q   <= rx_d;
    tx_q   <= tx_d;
    fend_q <= fend_d;
    tgt_q  <= tgt_d;
    rv_q   <= rv_d;
    rval_q <= rval_d;
    last_q <= last_d;
  end

  assign stat_o = '{frame_last: frame_last, more: more, pending: pending_q,
                    slot_free: slot_free};

  assign out_o.valid       = out_valid_q;
  assign out_o.tx_byte     = tx_q;
  assign out_o.frame_end   = fend_q;
  assign out_o.target_slot = tgt_q;
  assign out_o.read_valid  = rv_q;
  assign out_o.read_value  = rval_q;
  assign out_o.last        = last_q;

  // A finished read always closes its request.
  a_read_valid_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rv_q |-> last_q)
    else $error("read result not on the last result of its request");

  // The read value is zero unless a read has finished.
  a_read_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rv_q |-> rval_q == '0)
    else $error("read value shown without a finished read");

  // An open read always has bytes left to collect.
  a_pending_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> bytes_left_q != '0)
    else $error("read open with no bytes left");

  // A value or dummy frame never runs with its frame count used up.
  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_fire && ctrl_i.cw.dec |-> frames_left_q != '0)
    else $error("value frame emitted with no frames left");

endmodule

`default_nettype wire

// ===== sv/daisy_chain_spi_command_framer.sv =====
// Top level of the SPI daisy chain command framer.
//
// Requests enter on in_i and byte results leave on out_o, both valid/ready
// channels. A write, read or raw request expands into frames of L bytes, L
// being the chain length register (written through cfg_we_i/cfg_wdata_i).
// Only the target device's slot carries data; all other slots are zero.
// A write or read of N value bytes gives (1 + N) * L results, a raw byte L,
// a received byte (mode 3) one result, or none when no read is open.
// Sequencing: a request is taken in the idle step of the microcode sequencer,
// which then steps through its frames; each result is registered in the output
// register, one byte per cycle while that register has room. The next request
// is taken while the last result still waits in the output register.
// A stalled receiver holds the output register; the sequencer holds its frame
// or read step and counters until the result is taken.
// Reset sets the chain length to 4, closes any open read and empties the
// output register.
`default_nettype none

module daisy_chain_spi_command_framer #(
  parameter int unsigned MAX_CHAIN       = dscf_pkg::MAX_CHAIN,
  parameter int unsigned MAX_VALUE_BYTES = dscf_pkg::MAX_VALUE_BYTES
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [dscf_pkg::CFG_W-1:0] cfg_wdata_i,
  dscf_in_if.sink                         in_i,
  dscf_out_if.source                      out_o
);

  dscf_pkg::seq_ctrl_t ctrl;
  dscf_pkg::stat_t     stat;
  logic                in_ready;

  // Microcode sequencer.
  dscf_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  assign in_i.ready = in_ready;

  // Datapath with the read state and the result register.
  dscf_datapath #(
    .MAX_CHAIN       (MAX_CHAIN),
    .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_mode_i         (in_i.mode),
    .in_device_index_i (in_i.device_index),
    .in_command_byte_i (in_i.command_byte),
    .in_byte_count_i   (in_i.byte_count),
    .in_value_i        (in_i.value),
    .in_rx_byte_i      (in_i.rx_byte),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .out_o             (out_o)
  );

endmodule

`default_nettype wire
